// ===== rtl/union_find_set_engine_assert.svh =====
// Assertion helpers for the union-find engine.
`ifndef UNION_FIND_SET_ENGINE_ASSERT_SVH
`define UNION_FIND_SET_ENGINE_ASSERT_SVH

// Checked on clk_i, off while reset is asserted.
`define UFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on clk_i, also during reset.
`define UFS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/ufs_pkg.sv =====
package ufs_pkg;

  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned SIZE_W  = 11;

  localparam logic FUNC_FIND  = 1'b0;
  localparam logic FUNC_UNION = 1'b1;

  typedef logic [AW-1:0]     addr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_COMP,
    ST_FEND,
    ST_SZA,
    ST_SZB,
    ST_RES
  } ufs_state_e;

  typedef struct packed {
    logic clearing;
    logic idle;
  } ufs_stat_t;

  typedef struct packed {
    idx_t  root_index;
    size_t set_size;
    logic  merged;
  } ufs_res_t;

  // Out-of-range indexes saturate to the last entry.
  function automatic addr_t clamp_idx(input idx_t v);
    logic [31:0] w;
    w = 32'(v);
    if (w >= ENTRIES) begin
      return AW'(ENTRIES - 1);
    end
    return AW'(w);
  endfunction

endpackage

// ===== rtl/ufs_if.sv =====
interface ufs_in_if;
  logic                valid;
  logic                ready;
  logic                func;
  ufs_pkg::idx_t       first_index;
  ufs_pkg::idx_t       second_index;

  modport source(output valid, output func, output first_index, output second_index,
                 input ready);
  modport sink(input valid, input func, input first_index, input second_index,
               output ready);
endinterface

interface ufs_out_if;
  logic                valid;
  logic                ready;
  ufs_pkg::idx_t       root_index;
  ufs_pkg::size_t      set_size;
  logic                merged;

  modport source(output valid, output root_index, output set_size, output merged,
                 input ready);
  modport sink(input valid, input root_index, input set_size, input merged,
               output ready);
endinterface

// ===== rtl/union_find_set_engine.sv =====
// Disjoint-set engine, union by size with path compression, over 1024 elements.
// in_i  (valid/ready): func (0 find, 1 union), first_index, second_index.
// out_o (valid/ready): root_index, set_size, merged; exactly one item out per item in.
// Indexes beyond the table saturate to the last entry.
// Parent links and set sizes live in two synchronous RAMs (registered read);
// each find walks the parent chain one RAM read per cycle, then walks it again
// writing the root into every node on the path.
// Path length d in links is at most 10 with union by size; the walk loop
// through the parent RAM sets the time per item. A union whose two elements
// are already in one set skips the second size read and the merge write.
// Reset: a clearing pass writes every entry (parent = own index, size = 1)
// while in_i.ready is held low.
// A finished result sits in an output register; the engine takes the next item
// while that register waits on out_o.ready, and holds its next result until
// the register frees up.
`include "union_find_set_engine_assert.svh"

module union_find_set_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  ufs_in_if.sink    in_i,
  ufs_out_if.source out_o
);

  logic               res_valid;
  logic               res_ready;
  ufs_pkg::ufs_res_t  res;
  ufs_pkg::ufs_stat_t stat;

  logic               p_we;
  ufs_pkg::addr_t     p_waddr, p_wdata, p_raddr, p_rdata;
  logic               s_we;
  ufs_pkg::addr_t     s_waddr, s_raddr;
  ufs_pkg::size_t     s_wdata, s_rdata;

  logic               out_valid_q, out_valid_d;
  ufs_pkg::ufs_res_t  out_q;

  ufs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .stat_o      (stat),
    .p_we_o      (p_we),
    .p_waddr_o   (p_waddr),
    .p_wdata_o   (p_wdata),
    .p_raddr_o   (p_raddr),
    .p_rdata_i   (p_rdata),
    .s_we_o      (s_we),
    .s_waddr_o   (s_waddr),
    .s_wdata_o   (s_wdata),
    .s_raddr_o   (s_raddr),
    .s_rdata_i   (s_rdata)
  );

  // parent links
  ufs_ram #(
    .DEPTH (ufs_pkg::ENTRIES),
    .WIDTH (ufs_pkg::AW)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // set sizes, valid at roots
  ufs_ram #(
    .DEPTH (ufs_pkg::ENTRIES),
    .WIDTH (ufs_pkg::SIZE_W)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.root_index = out_q.root_index;
  assign out_o.set_size   = out_q.set_size;
  assign out_o.merged     = out_q.merged;

  `UFS_ASSERT(a_clear_blocks_in, stat.clearing |-> !in_i.ready, "item taken during clear")
  `UFS_ASSERT(a_res_held, res_valid && !res_ready |=> res_valid, "pending result dropped")
  `UFS_ASSERT(a_size_nonzero, out_o.valid |-> out_o.set_size != '0, "empty set reported")
  `UFS_ASSERT(a_merge_size, out_o.valid && out_o.merged |-> out_o.set_size > 11'd1, "merge too small")
  `UFS_ASSERT_ALWAYS(a_reset_clear, !rst_ni |=> !in_i.ready && !stat.idle, "input ready right after reset")

endmodule

// ===== rtl/ufs_ram.sv =====
module ufs_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ufs_ctrl.sv =====
module ufs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  ufs_in_if.sink             in_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output ufs_pkg::ufs_res_t  res_o,
  output ufs_pkg::ufs_stat_t stat_o,
  output logic               p_we_o,
  output ufs_pkg::addr_t     p_waddr_o,
  output ufs_pkg::addr_t     p_wdata_o,
  output ufs_pkg::addr_t     p_raddr_o,
  input  ufs_pkg::addr_t     p_rdata_i,
  output logic               s_we_o,
  output ufs_pkg::addr_t     s_waddr_o,
  output ufs_pkg::size_t     s_wdata_o,
  output ufs_pkg::addr_t     s_raddr_o,
  input  ufs_pkg::size_t     s_rdata_i
);

  ufs_pkg::ufs_state_e state_q, state_d;
  ufs_pkg::addr_t      clr_q, clr_d;
  logic                func_q, func_d;
  logic                pass_q, pass_d;
  ufs_pkg::addr_t      b_q, b_d;
  ufs_pkg::addr_t      node_q, node_d;
  ufs_pkg::addr_t      cur_q, cur_d;
  ufs_pkg::addr_t      root_q, root_d;
  ufs_pkg::addr_t      ra_q, ra_d;
  ufs_pkg::addr_t      rb_q, rb_d;
  ufs_pkg::size_t      sa_q, sa_d;
  ufs_pkg::ufs_res_t   res_q, res_d;
  ufs_pkg::addr_t      top, child;
  ufs_pkg::size_t      sum;

  // merge order: smaller set under larger, ties hang first root under second
  always_comb begin
    if (sa_q > s_rdata_i) begin
      top   = ra_q;
      child = rb_q;
    end else begin
      top   = rb_q;
      child = ra_q;
    end
    sum = ufs_pkg::size_t'(sa_q + s_rdata_i);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ufs_pkg::ST_CLEAR: begin
        if (clr_q == ufs_pkg::AW'(ufs_pkg::ENTRIES - 1)) begin
          state_d = ufs_pkg::ST_IDLE;
        end
      end
      ufs_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ufs_pkg::ST_WALK;
        end
      end
      ufs_pkg::ST_WALK: begin
        if (p_rdata_i == cur_q) begin
          state_d = (node_q == cur_q) ? ufs_pkg::ST_FEND : ufs_pkg::ST_COMP;
        end
      end
      ufs_pkg::ST_COMP: begin
        if (p_rdata_i == root_q) begin
          state_d = ufs_pkg::ST_FEND;
        end
      end
      ufs_pkg::ST_FEND: begin
        if (!pass_q && func_q == ufs_pkg::FUNC_UNION) begin
          state_d = ufs_pkg::ST_WALK;
        end else begin
          state_d = ufs_pkg::ST_SZA;
        end
      end
      ufs_pkg::ST_SZA: begin
        state_d = (ra_q == rb_q) ? ufs_pkg::ST_RES : ufs_pkg::ST_SZB;
      end
      ufs_pkg::ST_SZB: begin
        state_d = ufs_pkg::ST_RES;
      end
      ufs_pkg::ST_RES: begin
        if (res_ready_i) begin
          state_d = ufs_pkg::ST_IDLE;
        end
      end
      default: state_d = ufs_pkg::ST_CLEAR;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    clr_d     = clr_q;
    func_d    = func_q;
    pass_d    = pass_q;
    b_d       = b_q;
    node_d    = node_q;
    cur_d     = cur_q;
    root_d    = root_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    sa_d      = sa_q;
    res_d     = res_q;
    p_we_o    = 1'b0;
    p_waddr_o = cur_q;
    p_wdata_o = root_q;
    p_raddr_o = cur_q;
    s_we_o    = 1'b0;
    s_waddr_o = top;
    s_wdata_o = sum;
    s_raddr_o = ra_q;
    case (state_q)
      ufs_pkg::ST_CLEAR: begin
        p_we_o    = 1'b1;
        p_waddr_o = clr_q;
        p_wdata_o = clr_q;
        s_we_o    = 1'b1;
        s_waddr_o = clr_q;
        s_wdata_o = ufs_pkg::size_t'(1);
        clr_d     = clr_q + ufs_pkg::AW'(1);
      end
      ufs_pkg::ST_IDLE: begin
        p_raddr_o = ufs_pkg::clamp_idx(in_i.first_index);
        if (in_i.valid) begin
          func_d = in_i.func;
          b_d    = ufs_pkg::clamp_idx(in_i.second_index);
          node_d = ufs_pkg::clamp_idx(in_i.first_index);
          cur_d  = ufs_pkg::clamp_idx(in_i.first_index);
          pass_d = 1'b0;
        end
      end
      ufs_pkg::ST_WALK: begin
        if (p_rdata_i == cur_q) begin
          // root reached; restart at the node to compress the path
          root_d    = cur_q;
          cur_d     = node_q;
          p_raddr_o = node_q;
        end else begin
          cur_d     = p_rdata_i;
          p_raddr_o = p_rdata_i;
        end
      end
      ufs_pkg::ST_COMP: begin
        p_we_o    = 1'b1;
        p_waddr_o = cur_q;
        p_wdata_o = root_q;
        cur_d     = p_rdata_i;
        p_raddr_o = p_rdata_i;
      end
      ufs_pkg::ST_FEND: begin
        if (!pass_q && func_q == ufs_pkg::FUNC_UNION) begin
          ra_d      = root_q;
          pass_d    = 1'b1;
          node_d    = b_q;
          cur_d     = b_q;
          p_raddr_o = b_q;
        end else if (!pass_q) begin
          ra_d      = root_q;
          rb_d      = root_q;
          s_raddr_o = root_q;
        end else begin
          rb_d      = root_q;
          s_raddr_o = ra_q;
        end
      end
      ufs_pkg::ST_SZA: begin
        sa_d      = s_rdata_i;
        s_raddr_o = rb_q;
        res_d     = '{root_index: ufs_pkg::idx_t'(ra_q), set_size: s_rdata_i,
                      merged: 1'b0};
      end
      ufs_pkg::ST_SZB: begin
        p_we_o    = 1'b1;
        p_waddr_o = child;
        p_wdata_o = top;
        s_we_o    = 1'b1;
        s_waddr_o = top;
        s_wdata_o = sum;
        res_d     = '{root_index: ufs_pkg::idx_t'(top), set_size: sum, merged: 1'b1};
      end
      ufs_pkg::ST_RES: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ufs_pkg::ST_CLEAR;
      clr_q   <= '0;
      func_q  <= ufs_pkg::FUNC_FIND;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      func_q  <= func_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q    <= b_d;
    node_q <= node_d;
    cur_q  <= cur_d;
    root_q <= root_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    sa_q   <= sa_d;
    res_q  <= res_d;
  end

  assign in_i.ready      = (state_q == ufs_pkg::ST_IDLE);
  assign res_valid_o     = (state_q == ufs_pkg::ST_RES);
  assign res_o           = res_q;
  assign stat_o.clearing = (state_q == ufs_pkg::ST_CLEAR);
  assign stat_o.idle     = (state_q == ufs_pkg::ST_IDLE);

endmodule
